/* rtl/core/ersu_pkg.sv */
package ersu_pkg;

  localparam int unsigned SESSIONS     = 8;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned IDX_W        = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  localparam logic [1:0] OP_TCP      = 2'd0;
  localparam logic [1:0] OP_UDP      = 2'd1;
  localparam logic [1:0] OP_CLOSED   = 2'd2;
  localparam logic [1:0] OP_SHUTDOWN = 2'd3;

  localparam logic [15:0] CMD_NOP        = 16'h0000;
  localparam logic [15:0] CMD_SERVICES   = 16'h0004;
  localparam logic [15:0] CMD_IDENTITY   = 16'h0063;
  localparam logic [15:0] CMD_INTERFACES = 16'h0064;
  localparam logic [15:0] CMD_REGISTER   = 16'h0065;
  localparam logic [15:0] CMD_UNREGISTER = 16'h0066;
  localparam logic [15:0] CMD_RRDATA     = 16'h006F;
  localparam logic [15:0] CMD_UNITDATA   = 16'h0070;

  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_HDR_REPLY  = 3'd1;
  localparam logic [2:0] ACT_SERVICES   = 3'd2;
  localparam logic [2:0] ACT_IDENTITY   = 3'd3;
  localparam logic [2:0] ACT_INTERFACES = 3'd4;
  localparam logic [2:0] ACT_FWD_RR     = 3'd5;
  localparam logic [2:0] ACT_FWD_UNIT   = 3'd6;
  localparam logic [2:0] ACT_DLY_IDENT  = 3'd7;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADCMD  = 3'd1;
  localparam logic [2:0] ST_PROTO   = 3'd2;
  localparam logic [2:0] ST_NOMEM   = 3'd3;
  localparam logic [2:0] ST_BADSESS = 3'd4;

  localparam logic [15:0] PROTO_VERSION = 16'd1;
  localparam logic [15:0] FWD_OVERHEAD  = 16'd6;
  localparam logic [15:0] REG_REPLY_LEN = 16'd4;
  localparam logic [15:0] IFC_REPLY_LEN = 16'd2;
  localparam logic [15:0] DLY_DEFAULT   = 16'd2000;
  localparam logic [15:0] DLY_MIN       = 16'd500;

  typedef enum logic [1:0] {
    K_DIRECT,
    K_REGISTER,
    K_CLOSE,
    K_SHUTDOWN
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  hit;
    logic  last_idx;
    logic  out_free;
  } sts_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [2:0]         status;
    logic [31:0]        handle_out;
    logic [15:0]        reply_payload_length;
    logic signed [17:0] remaining_bytes;
    logic               close_request;
    logic [15:0]        close_socket_id;
    logic [15:0]        delay_bound;
    logic               last;
  } res_t;

endpackage

/* rtl/core/ersu_ctrl.sv */
module ersu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ersu_pkg::sts_t sts_i,
  output ersu_pkg::cmd_t cmd_o
);

  ersu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ersu_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ersu_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ersu_pkg::S_SCAN;
        end
      end
      ersu_pkg::S_SCAN: begin
        case (sts_i.kind)
          ersu_pkg::K_DIRECT: state_d = ersu_pkg::S_EMIT;
          ersu_pkg::K_REGISTER: begin
            if (sts_i.last_idx) begin
              state_d = ersu_pkg::S_EMIT;
            end
          end
          ersu_pkg::K_CLOSE: begin
            if (sts_i.hit || sts_i.last_idx) begin
              state_d = ersu_pkg::S_EMIT;
            end
          end
          ersu_pkg::K_SHUTDOWN: begin
            if (sts_i.last_idx && (!sts_i.hit || sts_i.out_free)) begin
              state_d = ersu_pkg::S_IDLE;
            end
          end
          default: state_d = ersu_pkg::S_IDLE;
        endcase
      end
      ersu_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          state_d = ersu_pkg::S_IDLE;
        end
      end
      default: state_d = ersu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.load    = 1'b0;
    case (state_q)
      ersu_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ersu_pkg::S_SCAN: begin
        case (sts_i.kind)
          ersu_pkg::K_REGISTER, ersu_pkg::K_CLOSE: cmd_o.step = 1'b1;
          ersu_pkg::K_SHUTDOWN: begin
            if (!sts_i.hit) begin
              cmd_o.step = 1'b1;
            end else if (sts_i.out_free) begin
              cmd_o.step = 1'b1;
              cmd_o.load = 1'b1;
            end
          end
          default: cmd_o.step = 1'b0;
        endcase
      end
      ersu_pkg::S_EMIT: cmd_o.load = sts_i.out_free;
      default: cmd_o.load = 1'b0;
    endcase
  end

endmodule

/* rtl/core/ersu_dp.sv */
module ersu_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     opcode_i,
  input  logic [15:0]    command_code_i,
  input  logic [15:0]    payload_length_i,
  input  logic [31:0]    handle_in_i,
  input  logic [31:0]    header_options_i,
  input  logic [15:0]    received_bytes_i,
  input  logic [15:0]    socket_id_i,
  input  logic [15:0]    protocol_version_i,
  input  logic [15:0]    register_flags_i,
  input  logic [15:0]    max_delay_request_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output ersu_pkg::res_t out_res_o,
  input  ersu_pkg::cmd_t cmd_i,
  output ersu_pkg::sts_t sts_o
);

  localparam int unsigned IW = ersu_pkg::IDX_W;
  localparam int unsigned N  = ersu_pkg::SESSIONS;

  logic [1:0]  op_q;
  logic [15:0] cmd_q, plen_q, rcv_q, sock_q, ver_q, flg_q, mdly_q;
  logic [31:0] hin_q, opts_q;

  logic [N-1:0] valid_q;
  logic [15:0]  table_q [N];

  logic [IW-1:0] idx_q, dup_idx_q, free_idx_q;
  logic          dup_q, free_q, hit_q;

  ersu_pkg::res_t out_q, res_c;
  logic           out_valid_q;

  ersu_pkg::kind_e kind_c;
  logic [17:0]     rem_c;
  logic            bad_c, udp_c, live_c, unreg_c, hit_c, match_c, above_c, out_free_c;
  logic [IW-1:0]   hidx_c, rd_idx_c;
  logic [15:0]     sock_rd_c, dly_c;

  assign rem_c  = {2'b00, rcv_q} - 18'(ersu_pkg::HEADER_BYTES) - {2'b00, plen_q};
  assign bad_c  = (opts_q != '0) || rem_c[17];
  assign udp_c  = (op_q == ersu_pkg::OP_UDP);
  assign hidx_c = IW'(hin_q - 32'd1);
  assign live_c = (hin_q != '0) && (hin_q <= 32'(N)) && valid_q[hidx_c];

  always_comb begin
    if (op_q == ersu_pkg::OP_SHUTDOWN) begin
      kind_c = ersu_pkg::K_SHUTDOWN;
    end else if (op_q == ersu_pkg::OP_CLOSED) begin
      kind_c = ersu_pkg::K_CLOSE;
    end else if (!bad_c && (op_q == ersu_pkg::OP_TCP) &&
                 (cmd_q == ersu_pkg::CMD_REGISTER) &&
                 (ver_q == ersu_pkg::PROTO_VERSION) && (flg_q == '0)) begin
      kind_c = ersu_pkg::K_REGISTER;
    end else begin
      kind_c = ersu_pkg::K_DIRECT;
    end
  end

  assign rd_idx_c  = (kind_c == ersu_pkg::K_DIRECT) ? hidx_c : idx_q;
  assign sock_rd_c = table_q[rd_idx_c];
  assign match_c   = valid_q[idx_q] && (table_q[idx_q] == sock_q);
  assign hit_c     = (kind_c == ersu_pkg::K_SHUTDOWN) ? valid_q[idx_q] : match_c;
  assign unreg_c   = (kind_c == ersu_pkg::K_DIRECT) && !bad_c && !udp_c &&
                     (op_q != ersu_pkg::OP_CLOSED) && (op_q != ersu_pkg::OP_SHUTDOWN) &&
                     (cmd_q == ersu_pkg::CMD_UNREGISTER) && live_c;

  always_comb begin
    above_c = 1'b0;
    for (int j = 0; j < N; j++) begin
      if ((IW'(j) > idx_q) && valid_q[j]) begin
        above_c = 1'b1;
      end
    end
  end

  always_comb begin
    if (mdly_q == '0) begin
      dly_c = ersu_pkg::DLY_DEFAULT;
    end else if (mdly_q < ersu_pkg::DLY_MIN) begin
      dly_c = ersu_pkg::DLY_MIN;
    end else begin
      dly_c = mdly_q;
    end
  end

  always_comb begin
    res_c.action               = ersu_pkg::ACT_NONE;
    res_c.status               = ersu_pkg::ST_OK;
    res_c.handle_out           = hin_q;
    res_c.reply_payload_length = '0;
    res_c.remaining_bytes      = '0;
    res_c.close_request        = 1'b0;
    res_c.close_socket_id      = '0;
    res_c.delay_bound          = '0;
    res_c.last                 = 1'b1;
    case (kind_c)
      ersu_pkg::K_SHUTDOWN: begin
        res_c.handle_out      = 32'(idx_q) + 32'd1;
        res_c.close_request   = 1'b1;
        res_c.close_socket_id = table_q[idx_q];
        res_c.last            = !above_c;
      end
      ersu_pkg::K_CLOSE: begin
        res_c.close_request   = hit_q;
        res_c.close_socket_id = hit_q ? sock_q : 16'd0;
      end
      ersu_pkg::K_REGISTER: begin
        res_c.remaining_bytes      = rem_c;
        res_c.action               = ersu_pkg::ACT_HDR_REPLY;
        res_c.reply_payload_length = ersu_pkg::REG_REPLY_LEN;
        if (dup_q) begin
          res_c.status     = ersu_pkg::ST_PROTO;
          res_c.handle_out = 32'(dup_idx_q) + 32'd1;
        end else if (!free_q) begin
          res_c.status = ersu_pkg::ST_NOMEM;
        end else begin
          res_c.handle_out = 32'(free_idx_q) + 32'd1;
        end
      end
      ersu_pkg::K_DIRECT: begin
        res_c.remaining_bytes = rem_c;
        if (bad_c) begin
          res_c.action = ersu_pkg::ACT_NONE;
        end else if (cmd_q == ersu_pkg::CMD_SERVICES) begin
          res_c.action = ersu_pkg::ACT_SERVICES;
        end else if (cmd_q == ersu_pkg::CMD_IDENTITY) begin
          if (udp_c) begin
            res_c.action      = ersu_pkg::ACT_DLY_IDENT;
            res_c.delay_bound = dly_c;
          end else begin
            res_c.action = ersu_pkg::ACT_IDENTITY;
          end
        end else if (cmd_q == ersu_pkg::CMD_INTERFACES) begin
          res_c.action               = ersu_pkg::ACT_INTERFACES;
          res_c.reply_payload_length = ersu_pkg::IFC_REPLY_LEN;
        end else if (udp_c) begin
          res_c.action = ersu_pkg::ACT_HDR_REPLY;
          res_c.status = ersu_pkg::ST_BADCMD;
        end else if (cmd_q == ersu_pkg::CMD_NOP) begin
          res_c.action = ersu_pkg::ACT_NONE;
        end else if (cmd_q == ersu_pkg::CMD_REGISTER) begin
          res_c.action               = ersu_pkg::ACT_HDR_REPLY;
          res_c.status               = ersu_pkg::ST_PROTO;
          res_c.reply_payload_length = ersu_pkg::REG_REPLY_LEN;
        end else if (cmd_q == ersu_pkg::CMD_UNREGISTER) begin
          if (live_c) begin
            res_c.close_request   = 1'b1;
            res_c.close_socket_id = sock_rd_c;
          end else begin
            res_c.action = ersu_pkg::ACT_HDR_REPLY;
            res_c.status = ersu_pkg::ST_BADSESS;
          end
        end else if ((cmd_q == ersu_pkg::CMD_RRDATA) || (cmd_q == ersu_pkg::CMD_UNITDATA)) begin
          if (plen_q < ersu_pkg::FWD_OVERHEAD) begin
            res_c.action               = ersu_pkg::ACT_HDR_REPLY;
            res_c.reply_payload_length = plen_q;
          end else if (live_c) begin
            res_c.action = (cmd_q == ersu_pkg::CMD_RRDATA) ? ersu_pkg::ACT_FWD_RR :
                                                            ersu_pkg::ACT_FWD_UNIT;
            res_c.reply_payload_length = plen_q - ersu_pkg::FWD_OVERHEAD;
          end else begin
            res_c.action = ersu_pkg::ACT_HDR_REPLY;
            res_c.status = ersu_pkg::ST_BADSESS;
          end
        end else begin
          res_c.action = ersu_pkg::ACT_HDR_REPLY;
          res_c.status = ersu_pkg::ST_BADCMD;
        end
      end
      default: res_c.last = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      cmd_q  <= command_code_i;
      plen_q <= payload_length_i;
      hin_q  <= handle_in_i;
      opts_q <= header_options_i;
      rcv_q  <= received_bytes_i;
      sock_q <= socket_id_i;
      ver_q  <= protocol_version_i;
      flg_q  <= register_flags_i;
      mdly_q <= max_delay_request_i;
    end
    if (cmd_i.step && (kind_c == ersu_pkg::K_REGISTER)) begin
      if (match_c && !dup_q) begin
        dup_idx_q <= idx_q;
      end
      if (!valid_q[idx_q] && !free_q) begin
        free_idx_q <= idx_q;
      end
    end
    if (cmd_i.load && (kind_c == ersu_pkg::K_REGISTER) && !dup_q && free_q) begin
      table_q[free_idx_q] <= sock_q;
    end
    if (cmd_i.load) begin
      out_q <= res_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      idx_q       <= '0;
      dup_q       <= 1'b0;
      free_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        idx_q  <= '0;
        dup_q  <= 1'b0;
        free_q <= 1'b0;
        hit_q  <= 1'b0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + IW'(1);
        if (kind_c == ersu_pkg::K_REGISTER) begin
          if (match_c) begin
            dup_q <= 1'b1;
          end
          if (!valid_q[idx_q]) begin
            free_q <= 1'b1;
          end
        end
        if ((kind_c == ersu_pkg::K_CLOSE || kind_c == ersu_pkg::K_SHUTDOWN) && hit_c) begin
          valid_q[idx_q] <= 1'b0;
          hit_q          <= 1'b1;
        end
      end
      if (cmd_i.load && (kind_c == ersu_pkg::K_REGISTER) && !dup_q && free_q) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (cmd_i.load && unreg_c) begin
        valid_q[hidx_c] <= 1'b0;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free_c = !out_valid_q || out_ready_i;

  assign sts_o.kind     = kind_c;
  assign sts_o.hit      = hit_c;
  assign sts_o.last_idx = (idx_q == IW'(N - 1));
  assign sts_o.out_free = out_free_c;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

/* rtl/core/encap_request_session_unit.sv */
// Channel   Direction  Contents
// s_axis    in         one header event: opcode in tuser, header and request words in tdata
// m_axis    out        one result word: action, status, handle, lengths, close request
//
// A direct request passes through the scan and emit states; emit waits for a free output register.
// Register and socket-closed events walk the session table one slot per
// cycle (a socket-closed event stops at its match); shutdown walks it too,
// but stalls at each live slot until the output register is free on m_axis.
// Reset clears all session valid bits and m_axis_tvalid and returns the control to idle.
// A new word is taken only after the previous one has finished and placed its results,
// if any, in the output register.
module encap_request_session_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] command_code, [31:16] payload_length, [63:32] handle_in,
  // [95:64] header_options, [111:96] received_bytes, [127:112] socket_id,
  // [143:128] protocol_version, [159:144] register_flags,
  // [175:160] max_delay_request
  input  logic [175:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] action, [5:3] status, [37:6] handle_out, [53:38] reply_payload_length,
  // [71:54] remaining_bytes, [72] close_request, [88:73] close_socket_id,
  // [104:89] delay_bound, [111:105] zero
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tlast
);

  ersu_pkg::cmd_t cmd;
  ersu_pkg::sts_t sts;
  ersu_pkg::res_t res;

  ersu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ersu_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .opcode_i            (s_axis_tuser),
    .command_code_i      (s_axis_tdata[15:0]),
    .payload_length_i    (s_axis_tdata[31:16]),
    .handle_in_i         (s_axis_tdata[63:32]),
    .header_options_i    (s_axis_tdata[95:64]),
    .received_bytes_i    (s_axis_tdata[111:96]),
    .socket_id_i         (s_axis_tdata[127:112]),
    .protocol_version_i  (s_axis_tdata[143:128]),
    .register_flags_i    (s_axis_tdata[159:144]),
    .max_delay_request_i (s_axis_tdata[175:160]),
    .out_ready_i         (m_axis_tready),
    .out_valid_o         (m_axis_tvalid),
    .out_res_o           (res),
    .cmd_i               (cmd),
    .sts_o               (sts)
  );

  assign m_axis_tdata = {7'd0, res.delay_bound, res.close_socket_id, res.close_request,
                         res.remaining_bytes, res.reply_payload_length, res.handle_out,
                         res.status, res.action};
  assign m_axis_tlast = res.last;

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ersu_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_EVENTS = 336;

  typedef struct {
    logic [1:0]  opcode;
    logic [15:0] command_code;
    logic [15:0] payload_length;
    logic [31:0] handle_in;
    logic [31:0] header_options;
    logic [15:0] received_bytes;
    logic [15:0] socket_id;
    logic [15:0] protocol_version;
    logic [15:0] register_flags;
    logic [15:0] max_delay_request;
  } hdr_event_t;

  class session_scoreboard;
    bit          live[SESSIONS];
    logic [15:0] sock_of[SESSIONS];
    res_t        expected_q[$];
    int          errors;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit handle_live(logic [31:0] h);
      return h >= 1 && h <= SESSIONS && live[h - 1];
    endfunction

    function void note_event(hdr_event_t ev);
      res_t r;
      int   n;
      int   k;
      int   remi;
      int   dup;
      int   free_slot;

      r = '0;
      r.last = 1'b1;
      r.handle_out = ev.handle_in;

      if (ev.opcode == OP_SHUTDOWN) begin
        n = 0;
        foreach (live[i]) if (live[i]) n++;
        k = 0;
        for (int i = 0; i < SESSIONS; i++) begin
          if (live[i]) begin
            live[i] = 1'b0;
            r = '0;
            r.action = ACT_NONE;
            r.status = ST_OK;
            r.handle_out = i + 1;
            r.close_request = 1'b1;
            r.close_socket_id = sock_of[i];
            r.last = (k == n - 1);
            expected_q.push_back(r);
            k++;
          end
        end
        return;
      end

      if (ev.opcode == OP_CLOSED) begin
        for (int i = 0; i < SESSIONS; i++) begin
          if (live[i] && sock_of[i] == ev.socket_id) begin
            live[i] = 1'b0;
            r.close_request = 1'b1;
            r.close_socket_id = ev.socket_id;
            break;
          end
        end
        expected_q.push_back(r);
        return;
      end

      remi = int'(ev.received_bytes) - int'(HEADER_BYTES) - int'(ev.payload_length);
      r.remaining_bytes = remi[17:0];

      if (ev.header_options != 0 || remi < 0) begin
        expected_q.push_back(r);
        return;
      end

      if (ev.command_code == CMD_SERVICES) begin
        r.action = ACT_SERVICES;
      end else if (ev.command_code == CMD_IDENTITY) begin
        if (ev.opcode == OP_UDP) begin
          r.action = ACT_DLY_IDENT;
          if (ev.max_delay_request == 0) r.delay_bound = DLY_DEFAULT;
          else if (ev.max_delay_request < DLY_MIN) r.delay_bound = DLY_MIN;
          else r.delay_bound = ev.max_delay_request;
        end else begin
          r.action = ACT_IDENTITY;
        end
      end else if (ev.command_code == CMD_INTERFACES) begin
        r.action = ACT_INTERFACES;
        r.reply_payload_length = IFC_REPLY_LEN;
      end else if (ev.opcode == OP_UDP) begin
        r.action = ACT_HDR_REPLY;
        r.status = ST_BADCMD;
      end else if (ev.command_code == CMD_NOP) begin
        r.action = ACT_NONE;
      end else if (ev.command_code == CMD_REGISTER) begin
        r.action = ACT_HDR_REPLY;
        r.reply_payload_length = REG_REPLY_LEN;
        if (ev.protocol_version != PROTO_VERSION || ev.register_flags != 0) begin
          r.status = ST_PROTO;
        end else begin
          dup = -1;
          free_slot = -1;
          for (int i = 0; i < SESSIONS; i++) begin
            if (dup < 0 && live[i] && sock_of[i] == ev.socket_id) dup = i;
            if (free_slot < 0 && !live[i]) free_slot = i;
          end
          if (dup >= 0) begin
            r.status = ST_PROTO;
            r.handle_out = dup + 1;
          end else if (free_slot < 0) begin
            r.status = ST_NOMEM;
          end else begin
            live[free_slot] = 1'b1;
            sock_of[free_slot] = ev.socket_id;
            r.handle_out = free_slot + 1;
          end
        end
      end else if (ev.command_code == CMD_UNREGISTER) begin
        if (handle_live(ev.handle_in)) begin
          live[ev.handle_in - 1] = 1'b0;
          r.close_request = 1'b1;
          r.close_socket_id = sock_of[ev.handle_in - 1];
          r.action = ACT_NONE;
        end else begin
          r.action = ACT_HDR_REPLY;
          r.status = ST_BADSESS;
        end
      end else if (ev.command_code == CMD_RRDATA || ev.command_code == CMD_UNITDATA) begin
        if (ev.payload_length < FWD_OVERHEAD) begin
          r.action = ACT_HDR_REPLY;
          r.reply_payload_length = ev.payload_length;
        end else if (handle_live(ev.handle_in)) begin
          r.action = (ev.command_code == CMD_RRDATA) ? ACT_FWD_RR : ACT_FWD_UNIT;
          r.reply_payload_length = ev.payload_length - FWD_OVERHEAD;
        end else begin
          r.action = ACT_HDR_REPLY;
          r.status = ST_BADSESS;
        end
      end else begin
        r.action = ACT_HDR_REPLY;
        r.status = ST_BADCMD;
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(logic [111:0] d, logic l);
      res_t e;
      res_t g;
      if (expected_q.size() == 0) begin
        $error("result word with no expectation waiting: %h last %b", d, l);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      g.action = d[2:0];
      g.status = d[5:3];
      g.handle_out = d[37:6];
      g.reply_payload_length = d[53:38];
      g.remaining_bytes = d[71:54];
      g.close_request = d[72];
      g.close_socket_id = d[88:73];
      g.delay_bound = d[104:89];
      g.last = l;
      compare_field("action", e.action, g.action);
      compare_field("status", e.status, g.status);
      compare_field("handle_out", e.handle_out, g.handle_out);
      compare_field("reply_payload_length", e.reply_payload_length,
                    g.reply_payload_length);
      compare_field("remaining_bytes", e.remaining_bytes, g.remaining_bytes);
      compare_field("close_request", e.close_request, g.close_request);
      compare_field("close_socket_id", e.close_socket_id, g.close_socket_id);
      compare_field("delay_bound", e.delay_bound, g.delay_bound);
      compare_field("last", e.last, g.last);
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;

  session_scoreboard sb = new();
  bit rush;
  int cycle_cnt;

  encap_request_session_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(15, 60);
  endfunction

  initial begin
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rush) begin
        m_axis_tready <= 1'b1;
      end else if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 4) == 0) hold = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_event(hdr_event_t ev);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= ev.opcode;
    s_axis_tdata <= {ev.max_delay_request, ev.register_flags, ev.protocol_version,
                     ev.socket_id, ev.received_bytes, ev.header_options,
                     ev.handle_in, ev.payload_length, ev.command_code};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(ev);
    gap = 0;
    if (!rush && $urandom_range(0, 99) < 45) gap = idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic hdr_event_t make_req(logic [1:0] op, logic [15:0] cmd,
                                          logic [15:0] plen, logic [31:0] hin,
                                          logic [15:0] sock);
    hdr_event_t ev;
    int total;
    total = 24 + int'(plen);
    ev.opcode = op;
    ev.command_code = cmd;
    ev.payload_length = plen;
    ev.handle_in = hin;
    ev.header_options = '0;
    ev.received_bytes = (total > 65535) ? 16'hFFFF : total[15:0];
    ev.socket_id = sock;
    ev.protocol_version = PROTO_VERSION;
    ev.register_flags = '0;
    ev.max_delay_request = '0;
    return ev;
  endfunction

  function automatic hdr_event_t random_event();
    hdr_event_t ev;
    int r;
    int total;
    logic [1:0] op;
    logic [15:0] cmd;
    logic [15:0] plen;
    logic [31:0] hin;
    logic [15:0] sock;

    if ($urandom_range(0, 99) < 8) begin
      ev.opcode = 2'($urandom_range(0, 3));
      ev.command_code = 16'($urandom);
      ev.payload_length = 16'($urandom);
      ev.handle_in = $urandom;
      ev.header_options = $urandom;
      ev.received_bytes = 16'($urandom);
      ev.socket_id = 16'($urandom);
      ev.protocol_version = 16'($urandom);
      ev.register_flags = 16'($urandom);
      ev.max_delay_request = 16'($urandom);
      return ev;
    end

    r = $urandom_range(0, 99);
    if (r < 65) op = OP_TCP;
    else if (r < 80) op = OP_UDP;
    else if (r < 96) op = OP_CLOSED;
    else op = OP_SHUTDOWN;

    case ($urandom_range(0, 19))
      0:         cmd = CMD_NOP;
      1:         cmd = CMD_SERVICES;
      2, 3:      cmd = CMD_IDENTITY;
      4:         cmd = CMD_INTERFACES;
      5, 6, 7, 8, 9: cmd = CMD_REGISTER;
      10, 11, 12: cmd = CMD_UNREGISTER;
      13, 14, 15: cmd = CMD_RRDATA;
      16, 17:    cmd = CMD_UNITDATA;
      default:   cmd = 16'($urandom);
    endcase

    r = $urandom_range(0, 99);
    if (r < 70) plen = 16'($urandom_range(0, 40));
    else if (r < 90) plen = 16'($urandom_range(0, 7));
    else plen = 16'($urandom_range(0, 1500));

    r = $urandom_range(0, 99);
    if (r < 80) hin = $urandom_range(1, SESSIONS);
    else if (r < 90) hin = $urandom_range(0, 1) ? 32'd0 : SESSIONS + 1;
    else hin = $urandom;

    sock = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));

    ev = make_req(op, cmd, plen, hin, sock);
    if ($urandom_range(0, 99) < 88) begin
      total = 24 + int'(plen) + $urandom_range(0, 30);
      ev.received_bytes = (total > 65535) ? 16'hFFFF : total[15:0];
    end else begin
      ev.received_bytes = 16'($urandom_range(0, 24 + int'(plen)));
    end
    if ($urandom_range(0, 99) < 5) ev.header_options = $urandom | 32'h1;
    if ($urandom_range(0, 99) < 10) ev.protocol_version = 16'($urandom);
    if ($urandom_range(0, 99) < 8) ev.register_flags = 16'($urandom);
    r = $urandom_range(0, 3);
    if (r == 0) ev.max_delay_request = '0;
    else if (r == 1) ev.max_delay_request = 16'($urandom_range(1, 499));
    else if (r == 2) ev.max_delay_request = 16'($urandom_range(500, 501));
    else ev.max_delay_request = 16'($urandom);
    return ev;
  endfunction

  initial begin
    hdr_event_t ev;

    rush = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_event(make_req(OP_TCP, CMD_NOP, 16'd0, 32'd0, 16'd0));
    send_event(make_req(OP_TCP, CMD_SERVICES, 16'd0, 32'd0, 16'd1));
    send_event(make_req(OP_TCP, CMD_IDENTITY, 16'd0, 32'd0, 16'd1));
    send_event(make_req(OP_TCP, CMD_INTERFACES, 16'd0, 32'd0, 16'd1));
    ev = make_req(OP_UDP, CMD_IDENTITY, 16'd0, 32'd0, 16'd2);
    send_event(ev);
    ev.max_delay_request = 16'd100;
    send_event(ev);
    ev.max_delay_request = 16'hFFFF;
    send_event(ev);
    send_event(make_req(OP_UDP, CMD_NOP, 16'd0, 32'd0, 16'd2));
    send_event(make_req(OP_TCP, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 16'd2));
    ev = make_req(OP_TCP, CMD_REGISTER, 16'd4, 32'd0, 16'd5);
    ev.protocol_version = 16'd2;
    send_event(ev);
    ev.protocol_version = PROTO_VERSION;
    ev.register_flags = 16'h8000;
    send_event(ev);
    send_event(make_req(OP_TCP, CMD_REGISTER, 16'd4, 32'd0, 16'd5));
    send_event(make_req(OP_TCP, CMD_REGISTER, 16'd4, 32'd0, 16'd5));
    for (int i = 0; i < SESSIONS - 1; i++)
      send_event(make_req(OP_TCP, CMD_REGISTER, 16'd4, 32'd0, 16'(16'hFFF0 + i)));
    send_event(make_req(OP_TCP, CMD_REGISTER, 16'd4, 32'd0, 16'hFFFF));
    send_event(make_req(OP_TCP, CMD_RRDATA, 16'd5, 32'd1, 16'd5));
    send_event(make_req(OP_TCP, CMD_RRDATA, 16'd30, 32'd1, 16'd5));
    send_event(make_req(OP_TCP, CMD_UNITDATA, 16'd6, 32'hFFFF_FFFF, 16'd5));
    send_event(make_req(OP_TCP, CMD_UNITDATA, 16'd6, 32'd3, 16'd5));
    send_event(make_req(OP_TCP, CMD_UNREGISTER, 16'd0, 32'd2, 16'd5));
    send_event(make_req(OP_TCP, CMD_UNREGISTER, 16'd0, 32'd0, 16'd5));
    ev = make_req(OP_TCP, CMD_SERVICES, 16'd0, 32'd0, 16'd5);
    ev.header_options = 32'hFFFF_FFFF;
    send_event(ev);
    ev = make_req(OP_TCP, CMD_SERVICES, 16'hFFFF, 32'd0, 16'd5);
    ev.received_bytes = 16'd0;
    send_event(ev);
    ev = make_req(OP_TCP, CMD_NOP, 16'd0, 32'd0, 16'd5);
    ev.received_bytes = 16'hFFFF;
    send_event(ev);
    send_event(make_req(OP_CLOSED, CMD_NOP, 16'd0, 32'hA5A5_A5A5, 16'd5));
    send_event(make_req(OP_CLOSED, CMD_NOP, 16'd0, 32'd7, 16'h1234));
    send_event(make_req(OP_SHUTDOWN, CMD_NOP, 16'd0, 32'd0, 16'd0));
    send_event(make_req(OP_SHUTDOWN, CMD_NOP, 16'd0, 32'd0, 16'd0));

    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 50 == 0) rush = ($urandom_range(0, 3) == 0);
      send_event(random_event());
    end
    rush = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
